/* rtl/can_body_module_frame_sequencer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the body-module frame sequencer
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CAN_BODY_MODULE_FRAME_SEQUENCER_TOP_DEFINES_SVH
`define CAN_BODY_MODULE_FRAME_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define CBFS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbfs_pkg.sv */
// ----------------------------------------------------------------------------
// cbfs_pkg
// Types, constants and the transmit frame table of the frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cbfs_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NUM_SLOTS   = 20;
  localparam int unsigned SLOT_W      = $clog2(NUM_SLOTS);
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMMO_ENABLED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRANKING_RPM = 8'd1;

  localparam logic [10:0] ID_STARTER   = 11'h350;
  localparam logic [10:0] ID_RELAY     = 11'h303;
  localparam logic [10:0] ID_CHALLENGE = 11'h714;
  localparam logic [10:0] ID_TRIGGER   = 11'h713;

  localparam logic [15:0] RPM_BASELINE = 16'h3200;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WAIT,
    MODE_TRIG,
    MODE_HALF,
    MODE_DONE
  } mode_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_TRIGGER  = 5'd0,
    SLOT_1F6      = 5'd1,
    SLOT_189      = 5'd2,
    SLOT_186      = 5'd3,
    SLOT_18A      = 5'd4,
    SLOT_217      = 5'd5,
    SLOT_2A9      = 5'd6,
    SLOT_2C6      = 5'd7,
    SLOT_5DA      = 5'd8,
    SLOT_36E      = 5'd9,
    SLOT_3A5      = 5'd10,
    SLOT_511      = 5'd11,
    SLOT_6FD      = 5'd12,
    SLOT_648      = 5'd13,
    SLOT_41A      = 5'd14,
    SLOT_66A      = 5'd15,
    SLOT_522      = 5'd16,
    SLOT_65C      = 5'd17,
    SLOT_41D      = 5'd18,
    SLOT_KEEPALIVE = 5'd19
  } slot_e;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] due;
    logic [15:0]          session;
    logic                 run;
    logic                 crank;
    logic [15:0]          enc;
    logic                 starter;
    logic                 relay;
    mode_e                mode;
  } job_t;

  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  function automatic logic [63:0] pack8(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                        logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                        logic [7:0] b6, logic [7:0] b7);
    return {b7, b6, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic frame_t frame_build(logic [SLOT_W-1:0] slot, job_t job);
    frame_t     f;
    logic       act;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] rs;
    act = job.run | job.crank;
    hi  = job.enc[15:8];
    lo  = job.enc[7:0];
    rs  = job.run ? 8'h1D : 8'h01;
    f   = '0;
    unique case (slot)
      SLOT_TRIGGER: f = '{ID_TRIGGER, 4'd8, pack8(job.session[15:8], job.session[7:0],
                                                  8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h00)};
      SLOT_1F6: f = '{11'h1F6, 4'd8, pack8(8'h00, job.run ? 8'h20 : 8'h00,
                                           {job.run, job.crank, 6'h02}, 8'h2D,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_189: f = '{11'h189, 4'd8, pack8(hi, lo, 8'h20, 8'h32, job.run ? 8'h70 : 8'h00,
                                           8'hB9, 8'h00, 8'h00)};
      SLOT_186: f = '{11'h186, 4'd7, pack8(act ? 8'h28 : 8'h00, act ? 8'h1C : 8'h00, hi, lo,
                                           8'h20, 8'h00, 8'h20, 8'h00)};
      SLOT_18A: f = '{11'h18A, 4'd6, pack8(hi, lo, 8'h00, 8'h06, job.run ? 8'hE8 : 8'hFE,
                                           8'h00, 8'h00, 8'h00)};
      SLOT_217: f = '{11'h217, 4'd8, pack8(8'h00, 8'h00, act ? 8'h70 : 8'h00, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h88)};
      SLOT_2A9: f = '{11'h2A9, 4'd1, pack8(8'hF4, 8'h00, 8'h00, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_2C6: f = '{11'h2C6, 4'd6, pack8(8'h00, 8'h00, 8'h00, 8'h40,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_5DA: f = '{11'h5DA, 4'd8, pack8(8'h41, job.run ? 8'h9D : 8'h89, 8'h00, 8'h00,
                                           8'hB9, 8'hFF, 8'hFF, 8'h00)};
      SLOT_36E: f = '{11'h36E, 4'd4, pack8(8'h09, 8'h99, 8'h09, 8'h99,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_3A5: f = '{11'h3A5, 4'd3, 64'd0};
      SLOT_511: f = '{11'h511, 4'd7, 64'd0};
      SLOT_6FD: f = '{11'h6FD, 4'd4, pack8(8'h00, 8'h00, 8'h99, job.run ? 8'h00 : 8'h20,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_648: f = '{11'h648, 4'd8, pack8(8'hC3, 8'hFF, 8'hF0, 8'h00,
                                           8'h00, 8'h7F, 8'hFE, 8'h18)};
      SLOT_41A: f = '{11'h41A, 4'd8, pack8(8'h00, job.run ? 8'h00 : 8'h03, 8'h00, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_66A: f = '{11'h66A, 4'd8, pack8(job.run ? 8'h00 : 8'h08, 8'hFF, 8'h00, rs, rs,
                                           8'hC0, 8'h00, 8'h00)};
      SLOT_522: f = '{11'h522, 4'd8, 64'd0};
      SLOT_65C: f = '{11'h65C, 4'd3, pack8(job.run ? 8'h78 : 8'h7A, 8'hFF, 8'h00, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_41D: f = '{11'h41D, 4'd4, pack8(8'h48, 8'hFE, 8'hFF, 8'h00,
                                           8'h00, 8'h00, 8'h00, 8'h00)};
      SLOT_KEEPALIVE: f = '{11'h5E2, 4'd2, 64'd0};
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* rtl/cbfs_if.sv */
// ----------------------------------------------------------------------------
// cbfs_if
// Valid/ready channels of the frame sequencer: input, result and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbfs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [10:0] rx_id;
  logic [63:0] rx_data;
  logic [15:0] rpm_sixteenths;

  modport source (output valid, cmd, rx_id, rx_data, rpm_sixteenths, input ready);
  modport sink   (input valid, cmd, rx_id, rx_data, rpm_sixteenths, output ready);
endinterface

interface cbfs_out_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [10:0] frame_id;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic        last;
  logic        starter_active;
  logic        relay_active;
  logic [2:0]  immo_state;

  modport source (output valid, frame_valid, frame_id, frame_length, frame_data, last,
                  starter_active, relay_active, immo_state, input ready);
  modport sink   (input valid, frame_valid, frame_id, frame_length, frame_data, last,
                  starter_active, relay_active, immo_state, output ready);
endinterface

interface cbfs_cfg_if;
  import cbfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/can_body_module_frame_sequencer_top.sv */
// Body-module CAN frame sequencer, engine controller side. An input item
// is taken whenever the job queue has room; the back end then delivers that
// item's results at one per cycle, while out_o.ready does not hold them back,
// through a registered output, so a tick gives as many results as frames
// fall due (1 to 20, 20 at most when the trigger, all periodic groups and the
// keepalive coincide) and a received frame, or a tick with nothing due, gives
// a single status result. The sustained rate is set by that one-result-per-
// cycle output register when ready is held high; the queue lets the next item
// be taken while a burst is still draining. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// can_body_module_frame_sequencer_top
// Front end, job queue and frame back end of the frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module can_body_module_frame_sequencer_top #(
  parameter int unsigned QueueDepth = cbfs_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbfs_in_if.sink    in_i,
  cbfs_cfg_if.sink   cfg_i,
  cbfs_out_if.source out_o
);
  import cbfs_pkg::*;

  logic q_ready, push, pop, head_valid;
  job_t job, head;

  cbfs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .job_o     (job)
  );

  cbfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cbfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

/* rtl/cbfs_front.sv */
// ----------------------------------------------------------------------------
// cbfs_front
// Accepts items, runs the immobiliser sequencer, flags and phase counters,
// and issues one job per item listing the frames that are due.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfs_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  cbfs_in_if.sink             in_i,
  cbfs_cfg_if.sink            cfg_i,
  input  wire logic           q_ready_i,
  output logic                push_o,
  output cbfs_pkg::job_t      job_o
);
  import cbfs_pkg::*;

  localparam logic [7:0] WAIT_TICKS  = 8'd200;
  localparam logic [7:0] RETRY_TICKS = 8'd100;
  localparam logic [7:0] HALF_TICKS  = 8'd2;
  localparam logic [7:0] DONE_TICKS  = 8'd3;
  localparam logic [7:0] TIMER_MAX   = 8'd255;
  localparam logic [7:0] PHASE_LAST  = 8'd199;
  localparam logic [4:0] SUB_LAST    = 5'd19;

  logic        immo_q;
  logic [11:0] crank_rpm_q;

  mode_e       mode_q, mode_d;
  logic [7:0]  timer_q, timer_d, timer_inc;
  logic [7:0]  phase_q, phase_d;
  logic [4:0]  sub20_q, sub20_d;
  logic [15:0] session_q, session_d;
  logic        starter_q, starter_d;
  logic        relay_q, relay_d;

  logic        accept, trig;
  logic        run, crank;
  logic [7:0]  rx_b4;

  assign in_i.ready  = q_ready_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      immo_q      <= 1'b0;
      crank_rpm_q <= 12'd550;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_IMMO_ENABLED) begin
        immo_q <= cfg_i.data[0];
      end else if (cfg_i.index == CFG_CRANKING_RPM) begin
        crank_rpm_q <= cfg_i.data[11:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      timer_q   <= '0;
      phase_q   <= '0;
      sub20_q   <= '0;
      session_q <= '0;
      starter_q <= 1'b0;
      relay_q   <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      timer_q   <= timer_d;
      phase_q   <= phase_d;
      sub20_q   <= sub20_d;
      session_q <= session_d;
      starter_q <= starter_d;
      relay_q   <= relay_d;
    end
  end

  assign run       = in_i.rpm_sixteenths > {crank_rpm_q, 4'b0000};
  assign crank     = (in_i.rpm_sixteenths != 16'd0) && !run;
  assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + 8'd1;
  assign rx_b4     = in_i.rx_data[39:32];

  always_comb begin
    mode_d    = mode_q;
    timer_d   = timer_q;
    phase_d   = phase_q;
    sub20_d   = sub20_q;
    session_d = session_q;
    starter_d = starter_q;
    relay_d   = relay_q;
    trig      = 1'b0;
    if (accept) begin
      if (!in_i.cmd) begin
        timer_d = timer_inc;
        unique case (mode_q)
          MODE_WAIT: begin
            if (timer_inc >= WAIT_TICKS) begin
              trig    = 1'b1;
              mode_d  = MODE_TRIG;
              timer_d = '0;
            end
          end
          MODE_TRIG: begin
            if (timer_inc >= RETRY_TICKS) begin
              trig    = 1'b1;
              timer_d = '0;
            end
          end
          MODE_HALF: begin
            if (timer_inc >= HALF_TICKS) begin
              mode_d  = MODE_TRIG;
              timer_d = '0;
            end
          end
          MODE_DONE: begin
            if (timer_inc >= DONE_TICKS) begin
              mode_d  = MODE_TRIG;
              timer_d = '0;
            end
          end
          default: ;
        endcase
        if (trig) begin
          session_d = session_q + 16'd1;
        end
        phase_d = (phase_q == PHASE_LAST) ? 8'd0 : phase_q + 8'd1;
        sub20_d = (sub20_q == SUB_LAST) ? 5'd0 : sub20_q + 5'd1;
      end else begin
        if (in_i.rx_id == ID_STARTER) begin
          starter_d = rx_b4[7];
          if ((rx_b4 != 8'd0) && (mode_q == MODE_IDLE) && immo_q) begin
            mode_d  = MODE_WAIT;
            timer_d = '0;
          end
        end else if (in_i.rx_id == ID_RELAY) begin
          relay_d = in_i.rx_data[41];
        end else if ((in_i.rx_id == ID_CHALLENGE) && immo_q) begin
          if (mode_q == MODE_TRIG) begin
            mode_d  = MODE_HALF;
            timer_d = '0;
          end else if (mode_q == MODE_HALF) begin
            mode_d  = MODE_DONE;
            timer_d = '0;
          end
        end
      end
    end
  end

  always_comb begin
    job_o         = '0;
    job_o.session = session_q;
    job_o.run     = run;
    job_o.crank   = crank;
    job_o.enc     = (in_i.rpm_sixteenths[15:4] == 12'd0) ? RPM_BASELINE : in_i.rpm_sixteenths;
    job_o.starter = starter_d;
    job_o.relay   = relay_d;
    job_o.mode    = mode_d;
    if (!in_i.cmd) begin
      job_o.due[SLOT_TRIGGER]      = trig;
      job_o.due[SLOT_2A9:SLOT_1F6] = {6{!phase_q[0]}};
      job_o.due[SLOT_2C6]          = (phase_q[1:0] == 2'd0);
      job_o.due[SLOT_41D:SLOT_5DA] = {11{sub20_q == 5'd0}};
      job_o.due[SLOT_KEEPALIVE]    = (phase_q == 8'd0);
    end
  end

  assign push_o = accept;

endmodule

`default_nettype wire

/* rtl/cbfs_queue.sv */
// ----------------------------------------------------------------------------
// cbfs_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfs_queue #(
  parameter int unsigned Depth = cbfs_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cbfs_pkg::job_t job_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output cbfs_pkg::job_t      head_o
);
  import cbfs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o      = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cbfs_back.sv */
// ----------------------------------------------------------------------------
// cbfs_back
// Walks the due frames of the head job, one result a cycle while out_o.ready
// does not stall it, into the output register; a job with nothing due gives one status result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "can_body_module_frame_sequencer_top_defines.svh"

module cbfs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire cbfs_pkg::job_t head_i,
  output logic                pop_o,
  cbfs_out_if.source          out_o
);
  import cbfs_pkg::*;

  logic                 started_q, started_d;
  logic [NUM_SLOTS-1:0] rem_q, rem_d;
  logic [NUM_SLOTS-1:0] work, rest;
  logic [SLOT_W-1:0]    slot;
  logic                 has, last, load;
  frame_t               frame;

  logic                 ovalid_q;
  logic                 ofv_q, olast_q, ostart_q, orelay_q;
  frame_t               oframe_q;
  mode_e                omode_q;

  assign work = started_q ? rem_q : head_i.due;
  assign has  = |work;

  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (work[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  assign rest  = work & ~(NUM_SLOTS'(1) << slot);
  assign last  = (rest == '0);
  assign load  = head_valid_i && (!ovalid_q || out_o.ready);
  assign pop_o = load && last;
  assign frame = has ? frame_build(slot, head_i) : '0;

  always_comb begin
    started_d = started_q;
    rem_d     = rem_q;
    if (load) begin
      started_d = !last;
      rem_d     = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      started_q <= started_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (load) begin
      ofv_q    <= has;
      oframe_q <= frame;
      olast_q  <= last;
      ostart_q <= head_i.starter;
      orelay_q <= head_i.relay;
      omode_q  <= head_i.mode;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.frame_valid    = ofv_q;
  assign out_o.frame_id       = oframe_q.id;
  assign out_o.frame_length   = oframe_q.len;
  assign out_o.frame_data     = oframe_q.data;
  assign out_o.last           = olast_q;
  assign out_o.starter_active = ostart_q;
  assign out_o.relay_active   = orelay_q;
  assign out_o.immo_state     = omode_q;

  `CBFS_ASSERT_HOLDS(a_started_has_head, clk_i, rst_ni, started_q, head_valid_i, "job in progress lost its queue entry")
  `CBFS_ASSERT_HOLDS(a_status_is_last, clk_i, rst_ni, out_o.valid && !out_o.frame_valid, out_o.last, "status result not marked last")
  `CBFS_ASSERT_NEXT(a_job_continues, clk_i, rst_ni, load && !last, started_q && head_valid_i && out_o.valid && !out_o.last, "frame burst broken off")

endmodule

`default_nettype wire
